>>> hw/rtl/wcpm_pkg.sv
// Shared types, character codes and class functions for the wildcard class pattern matcher.
package wcpm_pkg;

  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int unsigned POS_W       = 5;
  localparam int unsigned CFG_W       = 64;

  // Pattern codes
  localparam logic [7:0] CH_UPPER  = 8'h41;  // 'A'
  localparam logic [7:0] CH_ALPHA  = 8'h61;  // 'a'
  localparam logic [7:0] CH_DIGIT  = 8'h64;  // 'd'
  localparam logic [7:0] CH_ANY    = 8'h3F;  // '?'
  localparam logic [7:0] CH_BLANK  = 8'h20;  // ' '
  localparam logic [7:0] CH_SYMBOL = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_LF     = 8'h0A;  // '\n'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_NLRUN  = 2'd1,
    PH_SEEK   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    V_UNDECIDED = 2'd0,
    V_MATCHED   = 2'd1,
    V_FAILED    = 2'd2
  } verdict_e;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_crlf(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_BLANK) || (b == CH_TAB);
  endfunction

  function automatic logic class_match(input logic [7:0] b, input logic [7:0] p);
    logic m;
    case (p)
      CH_UPPER:  m = is_upper(b);
      CH_ALPHA:  m = is_alpha(b);
      CH_DIGIT:  m = is_digit(b);
      CH_ANY:    m = 1'b1;
      CH_BLANK:  m = is_blank(b);
      CH_LF:     m = is_crlf(b);
      CH_SYMBOL: m = !(is_blank(b) || is_crlf(b) || is_alpha(b) || is_digit(b));
      default:   m = (b == p);
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/wildcard_class_pattern_match.sv
// Streaming wildcard / character-class pattern matcher, one text byte per request.
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  --------------------------
//  in        in   in_valid_i / in_stall_o  text_byte_i, final_byte_i
//  out       out  out_valid_o / out_stall_i matched_o
//  cfg       in   cfg_we_i                 cfg_index_i, cfg_data_i
//
// One byte per cycle sustained unless a final byte waits for the output register; a byte is
// evaluated in the cycle after it enters the input register, and a final byte's verdict is
// written to the output register when that byte leaves the input register.
// The throughput is set by the match-state update loop.
// Reset clears the match state and the pattern registers; no clearing pass.
// Only a final byte needs the output register, so other bytes flow on while a
// verdict waits under out_stall_i.
module wildcard_class_pattern_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [wcpm_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   text_byte_i,
  input  logic                         final_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         matched_o
);

  // Configuration
  logic [wcpm_pkg::POS_W-1:0] len_q;
  logic [wcpm_pkg::CFG_W-1:0] pat_low_q, pat_high_q;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;

  // Match state
  logic [wcpm_pkg::POS_W-1:0] pos_q, pos_d;
  wcpm_pkg::phase_e           phase_q, phase_d;
  wcpm_pkg::verdict_e         verdict_q, verdict_d;

  // Output register
  logic out_valid_q, matched_q;

  logic                       out_free, s1_go, in_take;
  logic [wcpm_pkg::POS_W-1:0] used_len, pos_inc;
  logic [7:0]                 pat [wcpm_pkg::MAX_PATTERN];
  logic [7:0]                 cur_char;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_final_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  assign used_len = (len_q > wcpm_pkg::POS_W'(wcpm_pkg::MAX_PATTERN)) ?
                    wcpm_pkg::POS_W'(wcpm_pkg::MAX_PATTERN) : len_q;
  assign pos_inc  = pos_q + wcpm_pkg::POS_W'(1);

  always_comb begin
    for (int k = 0; k < wcpm_pkg::MAX_PATTERN; k++) begin
      if (k < 8) begin
        pat[k] = pat_low_q[8*k +: 8];
      end else begin
        pat[k] = pat_high_q[8*(k-8) +: 8];
      end
    end
  end

  // Only read while pos_q < used_len, so the low bits always address a live character
  assign cur_char = pat[pos_q[wcpm_pkg::PAT_IDX_W-1:0]];

  // Per-byte state update
  always_comb begin
    wcpm_pkg::phase_e ph;
    logic             adv;
    wcpm_pkg::phase_e adv_phase;
    pos_d     = pos_q;
    phase_d   = phase_q;
    verdict_d = verdict_q;
    ph        = phase_q;
    adv       = 1'b0;
    adv_phase = wcpm_pkg::PH_NORMAL;
    if (verdict_q == wcpm_pkg::V_UNDECIDED) begin
      if (pos_q >= used_len) begin
        verdict_d = (used_len == '0) ? wcpm_pkg::V_FAILED : wcpm_pkg::V_MATCHED;
      end else if (ph == wcpm_pkg::PH_NLRUN && wcpm_pkg::is_crlf(s1_byte_q)) begin
        // still inside the CR/LF run
      end else begin
        if (ph == wcpm_pkg::PH_NLRUN) begin
          ph = wcpm_pkg::PH_NORMAL;
        end
        if (ph == wcpm_pkg::PH_SEEK) begin
          if (wcpm_pkg::class_match(s1_byte_q, cur_char)) begin
            adv       = 1'b1;
            adv_phase = wcpm_pkg::PH_NORMAL;
          end
        end else begin
          phase_d = wcpm_pkg::PH_NORMAL;
          if (cur_char == wcpm_pkg::CH_LF) begin
            if (wcpm_pkg::is_crlf(s1_byte_q)) begin
              adv       = 1'b1;
              adv_phase = wcpm_pkg::PH_NLRUN;
            end else begin
              verdict_d = wcpm_pkg::V_FAILED;
            end
          end else if (cur_char == wcpm_pkg::CH_STAR) begin
            adv       = 1'b1;
            adv_phase = wcpm_pkg::PH_SEEK;
          end else if (wcpm_pkg::class_match(s1_byte_q, cur_char)) begin
            adv       = 1'b1;
            adv_phase = wcpm_pkg::PH_NORMAL;
          end else begin
            verdict_d = wcpm_pkg::V_FAILED;
          end
        end
        if (adv) begin
          pos_d = pos_inc;
          if (pos_inc >= used_len) begin
            verdict_d = wcpm_pkg::V_MATCHED;
          end else begin
            phase_d = adv_phase;
          end
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pat_low_q  <= '0;
      pat_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wcpm_pkg::REG_LENGTH: len_q      <= cfg_data_i[wcpm_pkg::POS_W-1:0];
        wcpm_pkg::REG_LOW:    pat_low_q  <= cfg_data_i;
        wcpm_pkg::REG_HIGH:   pat_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= text_byte_i;
      s1_final_q <= final_byte_i;
    end
  end

  // Match state: cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= wcpm_pkg::PH_NORMAL;
      verdict_q <= wcpm_pkg::V_UNDECIDED;
    end else if (s1_go) begin
      if (s1_final_q) begin
        pos_q     <= '0;
        phase_q   <= wcpm_pkg::PH_NORMAL;
        verdict_q <= wcpm_pkg::V_UNDECIDED;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        verdict_q <= verdict_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_final_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_final_q) begin
      matched_q <= (verdict_d == wcpm_pkg::V_MATCHED);
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule
